>>> src/csw_pkg.sv
// Shared types and constants for the counting semaphore wait engine.
package csw_pkg;

   localparam int NUM_SEMS_DEF  = 16;
   localparam int NUM_PRIOS_DEF = 16;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 4;
   localparam int PRIO_W   = 4;
   localparam int INIT_W   = 15;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE  = 2'd0,
      ACT_PEND    = 2'd1,
      ACT_POST    = 2'd2,
      ACT_TIMEOUT = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 3'd0,
      STS_BLOCKED    = 3'd1,
      STS_WRONG_TYPE = 3'd2,
      STS_OVERFLOW   = 3'd3,
      STS_NO_FREE    = 3'd4,
      STS_TIMED_OUT  = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      action_type          action;
      logic                slot_ok;
      logic                create_ok;
      logic                prio_ok;
      logic [PRIO_W-1:0]   task_prio;
      logic [INIT_W-1:0]   init_count;
   } op_type;

   typedef struct packed {
      status_type          status;
      logic                woke_valid;
      logic [PRIO_W-1:0]   woke_prio;
      logic [COUNT_W-1:0]  count_now;
      logic                wr_en;
      logic [COUNT_W-1:0]  new_count;
   } upd_type;

endpackage

>>> src/csw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module csw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/csw_update.sv
// Read-modify-write logic for one semaphore entry: count and wait bitmap.
module csw_update #(
   parameter int NUM_PRIOS = csw_pkg::NUM_PRIOS_DEF
) (
   input  csw_pkg::op_type                 op,
   input  logic [csw_pkg::COUNT_W-1:0]     rd_count,
   input  logic [NUM_PRIOS-1:0]            rd_map,
   output csw_pkg::upd_type                upd,
   output logic [NUM_PRIOS-1:0]            new_map
);

   logic [NUM_PRIOS-1:0]          prio_mask;
   logic [NUM_PRIOS-1:0]          low_bit;
   logic [csw_pkg::PRIO_W-1:0]    low_idx;

   assign prio_mask = op.prio_ok ? (NUM_PRIOS'(1) << op.task_prio) : '0;
   // isolate lowest waiting priority
   assign low_bit   = rd_map & (~rd_map + NUM_PRIOS'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NUM_PRIOS; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | csw_pkg::PRIO_W'(i);
         end
      end
   end

   always_comb begin
      upd            = '0;
      upd.status     = csw_pkg::STS_OK;
      upd.new_count  = rd_count;
      new_map        = rd_map;
      unique case (op.action)
         csw_pkg::ACT_CREATE: begin
            if (!op.create_ok) begin
               upd.status = csw_pkg::STS_NO_FREE;
            end else begin
               upd.wr_en     = 1'b1;
               upd.new_count = csw_pkg::COUNT_W'(op.init_count);
               new_map       = '0;
            end
         end
         csw_pkg::ACT_PEND: begin
            if (!op.slot_ok) begin
               upd.status = csw_pkg::STS_WRONG_TYPE;
            end else if (rd_count != '0) begin
               upd.wr_en     = 1'b1;
               upd.new_count = rd_count - csw_pkg::COUNT_W'(1);
            end else if (op.prio_ok) begin
               upd.wr_en  = 1'b1;
               new_map    = rd_map | prio_mask;
               upd.status = csw_pkg::STS_BLOCKED;
            end else begin
               upd.status = csw_pkg::STS_WRONG_TYPE;
            end
         end
         csw_pkg::ACT_POST: begin
            if (!op.slot_ok) begin
               upd.status = csw_pkg::STS_WRONG_TYPE;
            end else if (rd_map != '0) begin
               upd.wr_en      = 1'b1;
               new_map        = rd_map & ~low_bit;
               upd.woke_valid = 1'b1;
               upd.woke_prio  = low_idx;
            end else if (rd_count != csw_pkg::COUNT_MAX) begin
               upd.wr_en     = 1'b1;
               upd.new_count = rd_count + csw_pkg::COUNT_W'(1);
            end else begin
               upd.status = csw_pkg::STS_OVERFLOW;
            end
         end
         csw_pkg::ACT_TIMEOUT: begin
            if (!op.slot_ok) begin
               upd.status = csw_pkg::STS_WRONG_TYPE;
            end else begin
               upd.wr_en  = 1'b1;
               new_map    = rd_map & ~prio_mask;
               upd.status = csw_pkg::STS_TIMED_OUT;
            end
         end
         default: begin
            upd.status = csw_pkg::STS_WRONG_TYPE;
         end
      endcase
      if (upd.status == csw_pkg::STS_WRONG_TYPE || upd.status == csw_pkg::STS_NO_FREE) begin
         upd.count_now = '0;
      end else begin
         upd.count_now = upd.new_count;
      end
   end

endmodule

>>> src/counting_semaphore_wait_engine_unit.sv
// Top level of the counting semaphore wait engine: control, slot allocation, result beat.
//
// One request beat is taken when start is high and busy is low. The addressed
// semaphore entry (count and wait bitmap) is read from the entry RAM at that
// edge, updated and written back in the next cycle, and the result beat is
// driven with rsp_valid high for exactly one cycle after that; the receiver
// cannot stall it, so it must take every beat. busy is high for the one cycle
// of the update, so the next request is taken only once it is done, set by the
// read-then-write of the single entry RAM. Slots are allocated in index order
// and never freed, so a slot counts as created when it lies below the
// allocation pointer; no clearing pass is needed after reset.
module counting_semaphore_wait_engine_unit #(
   parameter int NUM_SEMS  = csw_pkg::NUM_SEMS_DEF,
   parameter int NUM_PRIOS = csw_pkg::NUM_PRIOS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [csw_pkg::ACTION_W-1:0]  req_action,
   input  logic [csw_pkg::ID_W-1:0]      req_sem_id,
   input  logic [csw_pkg::PRIO_W-1:0]    req_task_prio,
   input  logic [csw_pkg::INIT_W-1:0]    req_init_count,
   output logic                          rsp_valid,
   output logic [csw_pkg::STATUS_W-1:0]  rsp_status,
   output logic [csw_pkg::ID_W-1:0]      rsp_new_sem,
   output logic                          rsp_woke_valid,
   output logic [csw_pkg::PRIO_W-1:0]    rsp_woke_prio,
   output logic [csw_pkg::COUNT_W-1:0]   rsp_count_now
);

   localparam int ADDR_W      = $clog2(NUM_SEMS);
   localparam int NF_W        = $clog2(NUM_SEMS + 1);
   localparam int CMP_W       = NF_W + csw_pkg::ID_W;
   localparam int PRIO_CMP_W  = $clog2(NUM_PRIOS) + csw_pkg::PRIO_W + 1;
   localparam int WORD_W      = csw_pkg::COUNT_W + NUM_PRIOS;

   csw_pkg::state_type     state_ff, state_in;
   logic [NF_W-1:0]        next_free_ff, next_free_in;
   csw_pkg::op_type        op_ff, op_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;

   logic                           rsp_valid_ff;
   logic [csw_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [csw_pkg::ID_W-1:0]       rsp_new_sem_ff;
   logic                           rsp_woke_valid_ff;
   logic [csw_pkg::PRIO_W-1:0]     rsp_woke_prio_ff;
   logic [csw_pkg::COUNT_W-1:0]    rsp_count_now_ff;

   logic                   accept;
   logic                   exec;
   logic [CMP_W-1:0]       id_wide;
   logic [CMP_W-1:0]       nf_wide;
   logic [WORD_W-1:0]      rd_word;
   logic [WORD_W-1:0]      wr_word;
   logic [NUM_PRIOS-1:0]   new_map;
   csw_pkg::upd_type       upd;
   logic                   alloc;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      exec     = 1'b0;
      unique case (state_ff)
         csw_pkg::ST_IDLE: begin
            if (start) begin
               state_in = csw_pkg::ST_EXEC;
            end
         end
         csw_pkg::ST_EXEC: begin
            busy     = 1'b1;
            exec     = 1'b1;
            state_in = csw_pkg::ST_IDLE;
         end
         default: begin
            state_in = csw_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept = start && !busy;

   // request decode
   assign id_wide = CMP_W'(req_sem_id);
   assign nf_wide = CMP_W'(next_free_ff);

   always_comb begin
      op_in.action     = csw_pkg::action_type'(req_action);
      op_in.slot_ok    = id_wide < nf_wide;
      op_in.create_ok  = nf_wide < CMP_W'(NUM_SEMS);
      op_in.prio_ok    = PRIO_CMP_W'(req_task_prio) < PRIO_CMP_W'(NUM_PRIOS);
      op_in.task_prio  = req_task_prio;
      op_in.init_count = req_init_count;
      if (op_in.action == csw_pkg::ACT_CREATE) begin
         addr_in = nf_wide[ADDR_W-1:0];
      end else begin
         addr_in = id_wide[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_in;
         addr_ff <= addr_in;
      end
   end

   // entry storage: {wait bitmap, count}
   csw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_SEMS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (exec && upd.wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (addr_in),
      .rd_data (rd_word)
   );

   csw_update #(
      .NUM_PRIOS (NUM_PRIOS)
   ) u_update (
      .op       (op_ff),
      .rd_count (rd_word[csw_pkg::COUNT_W-1:0]),
      .rd_map   (rd_word[csw_pkg::COUNT_W +: NUM_PRIOS]),
      .upd      (upd),
      .new_map  (new_map)
   );

   assign wr_word = {new_map, upd.new_count};

   // slot allocation
   assign alloc = exec && (op_ff.action == csw_pkg::ACT_CREATE) && op_ff.create_ok;

   always_comb begin
      next_free_in = next_free_ff;
      if (alloc) begin
         next_free_in = next_free_ff + NF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
      end else begin
         next_free_ff <= next_free_in;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff     <= upd.status;
         rsp_new_sem_ff    <= alloc ? nf_wide[csw_pkg::ID_W-1:0] : '0;
         rsp_woke_valid_ff <= upd.woke_valid;
         rsp_woke_prio_ff  <= upd.woke_prio;
         rsp_count_now_ff  <= upd.count_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_sem    = rsp_new_sem_ff;
   assign rsp_woke_valid = rsp_woke_valid_ff;
   assign rsp_woke_prio  = rsp_woke_prio_ff;
   assign rsp_count_now  = rsp_count_now_ff;

endmodule
